>>> rtl/etg_pkg.sv
package etg_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] PI_E15 = 64'd3141592653589793;
    localparam logic [63:0] FIVE_P9 = 64'd1953125;
    localparam logic [63:0] FIVE_P15 = 64'd30517578125;
    localparam logic [63:0] PI_Q30 = ((PI_E15 / FIVE_P15) << 15)
                                   + (((PI_E15 % FIVE_P15) << 15) / FIVE_P15);
    localparam logic [63:0] OMEGA_NUM = ((PI_E15 / FIVE_P9) << 31)
                                      + (((PI_E15 % FIVE_P9) << 31) / FIVE_P9);
    localparam logic [63:0] MAG_POS_MAX = 64'd140737488355327;
    localparam logic [63:0] MAG_NEG_MAX = 64'd140737488355328;

    localparam logic [2:0] CFG_START_TIME = 3'd0;
    localparam logic [2:0] CFG_END_TIME = 3'd1;
    localparam logic [2:0] CFG_START_POSITION = 3'd2;
    localparam logic [2:0] CFG_END_POSITION = 3'd3;
    localparam logic [2:0] CFG_SAMPLE_INTERVAL = 3'd4;
    localparam logic [2:0] CFG_AXIS_RATIO = 3'd5;

    typedef struct packed {
        logic [31:0] start_time;
        logic [31:0] end_time;
        logic [30:0] start_position;
        logic [30:0] end_position;
        logic [19:0] sample_interval;
        logic [15:0] axis_ratio;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_DUR,
        OP_KSI,
        OP_PHASE,
        OP_ANG,
        OP_A2,
        OP_SIN_MUL,
        OP_SIN_DIV,
        OP_SIN,
        OP_COS_MUL,
        OP_COS_DIV,
        OP_COS,
        OP_C2,
        OP_S2,
        OP_RR,
        OP_EE,
        OP_U,
        OP_RM,
        OP_SR,
        OP_NE,
        OP_INVE,
        OP_GV,
        OP_KP,
        OP_HV1,
        OP_HV,
        OP_DPOS,
        OP_OM,
        OP_VEL1,
        OP_VEL,
        OP_ACL1,
        OP_ACL2,
        OP_ACL
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT,
        ST_ERR
    } state_t;

    typedef enum logic [1:0] {
        U_MUL,
        U_DIV,
        U_SQRT
    } unit_t;

    typedef struct packed {
        logic accept;
        logic issue;
        logic load_ok;
        logic load_err;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic go;
        logic err;
        logic done;
        logic j_last;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/elliptic_trajectory_generator.sv
// Elliptic point-to-point trajectory generator. Each input beat with restart
// high begins a move at sample zero, and each later beat with restart low
// yields the next sample (time, position, velocity, acceleration) until the
// beat flagged last; a beat with restart low while no move is active yields
// nothing, and bad settings yield one beat with status high. A sample is
// computed one operation at a time from six divisions (duration, phase,
// three ellipse ratios and the angular rate) on the shared radix-2 divider,
// two square roots and 45 products on the partial-product multiplier, the
// Taylor series divisions by small constants among them as reciprocal
// multiplies. A stalled output beat holds back the next result but not the
// next input beat, which is taken as soon as the previous result sits in
// the output register. Configuration writes are accepted every cycle and
// must only be made while the block is idle.
module elliptic_trajectory_generator
    import etg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        sample_time,
    output logic [30:0]        position,
    output logic signed [47:0] velocity,
    output logic signed [47:0] acceleration,
    output logic               last,
    output logic               status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_time <= 32'd0;
            cfg_reg.end_time <= 32'd1000000;
            cfg_reg.start_position <= 31'd0;
            cfg_reg.end_position <= 31'd0;
            cfg_reg.sample_interval <= 20'd1000;
            cfg_reg.axis_ratio <= 16'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_START_TIME:      cfg_reg.start_time <= cfg_data;
                CFG_END_TIME:        cfg_reg.end_time <= cfg_data;
                CFG_START_POSITION:  cfg_reg.start_position <= cfg_data[30:0];
                CFG_END_POSITION:    cfg_reg.end_position <= cfg_data[30:0];
                CFG_SAMPLE_INTERVAL: cfg_reg.sample_interval <= cfg_data[19:0];
                CFG_AXIS_RATIO:      cfg_reg.axis_ratio <= cfg_data[15:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    etg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    etg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .restart      (restart),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_time  (sample_time),
        .position     (position),
        .velocity     (velocity),
        .acceleration (acceleration),
        .last         (last),
        .status       (status)
    );

endmodule

>>> rtl/etg_mul.sv
module etg_mul
    import etg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic [5:0]  sh,
    output logic        done,
    output logic [63:0] res
);

    logic         busy_reg, busy_next;
    logic         fin_reg, fin_next;
    logic         done_reg, done_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic [63:0]  a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [5:0]   sh_reg, sh_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  res_reg, res_next;
    logic [31:0]  a_half, b_half;
    logic [63:0]  part;
    logic [6:0]   part_sh;
    logic [127:0] shifted;

    assign a_half = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];
    assign part = 64'(a_half) * 64'(b_half);
    assign part_sh = {({1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]}), 5'b0};
    assign shifted = acc_reg >> sh_reg;

    always_comb
    begin
        busy_next = busy_reg;
        fin_next = 1'b0;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        a_next = a_reg;
        b_next = b_reg;
        sh_next = sh_reg;
        acc_next = acc_reg;
        res_next = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 2'd0;
            a_next = a;
            b_next = b;
            sh_next = sh;
            acc_next = '0;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + ({64'b0, part} << part_sh);
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
                fin_next = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            res_next = (|shifted[127:64]) ? '1 : shifted[63:0];
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg <= fin_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        sh_reg <= sh_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res = res_reg;

endmodule

>>> rtl/etg_div.sv
module etg_div
    import etg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] n,
    input  logic [63:0] d,
    output logic        done,
    output logic [63:0] q,
    output logic [63:0] r
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] d_reg, d_next;
    logic [64:0] trial;

    assign trial = {rem_reg, quo_reg[63]} - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        d_next = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 6'd0;
            rem_next = '0;
            quo_next = n;
            d_next = d;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[62:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign q = quo_reg;
    assign r = rem_reg;

endmodule

>>> rtl/etg_sqrt.sv
module etg_sqrt
    import etg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] v,
    output logic        done,
    output logic [63:0] s
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        v_next = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 5'd0;
            v_next = v;
            res_next = '0;
            bit_next = 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign s = res_reg;

endmodule

>>> rtl/etg_dp.sv
module etg_dp
    import etg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               restart,
    input  cmd_t               cmd,
    output stat_t              stat,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        sample_time,
    output logic [30:0]        position,
    output logic signed [47:0] velocity,
    output logic signed [47:0] acceleration,
    output logic               last,
    output logic               status
);

    function automatic logic [47:0] sat48(input logic [63:0] mag, input logic neg);
        logic [63:0] m;
        begin
            if (neg)
            begin
                m = (mag > MAG_NEG_MAX) ? MAG_NEG_MAX : mag;
                m = ~m + 64'd1;
            end
            else
            begin
                m = (mag > MAG_POS_MAX) ? MAG_POS_MAX : mag;
            end
            return m[47:0];
        end
    endfunction

    // Reciprocals in Q40 of the Taylor series divisors. The quotient they give
    // is at most one short and is corrected by one compare and subtract.
    function automatic logic [63:0] recip_q40(input logic [7:0] dv);
        logic [63:0] r;
        begin
            case (dv)
                8'd6:    r = (64'd1 << 40) / 64'd6;
                8'd12:   r = (64'd1 << 40) / 64'd12;
                8'd20:   r = (64'd1 << 40) / 64'd20;
                8'd30:   r = (64'd1 << 40) / 64'd30;
                8'd42:   r = (64'd1 << 40) / 64'd42;
                8'd56:   r = (64'd1 << 40) / 64'd56;
                8'd72:   r = (64'd1 << 40) / 64'd72;
                8'd90:   r = (64'd1 << 40) / 64'd90;
                8'd110:  r = (64'd1 << 40) / 64'd110;
                8'd132:  r = (64'd1 << 40) / 64'd132;
                8'd156:  r = (64'd1 << 40) / 64'd156;
                8'd182:  r = (64'd1 << 40) / 64'd182;
                8'd210:  r = (64'd1 << 40) / 64'd210;
                default: r = 64'd0;
            endcase
            return r;
        end
    endfunction

    logic        active_reg;
    logic [31:0] idx_reg;
    logic [31:0] whole_reg;
    logic        remnz_reg;
    logic [32:0] k_reg;
    logic [31:0] tau_reg;
    logic [32:0] x_reg;
    logic [2:0]  j_reg;
    logic [63:0] ang_reg, a2_reg, acc_reg, tmp_reg, sn_reg, cs_reg;
    logic [63:0] c2_reg, s2_reg, rr_reg, ee_reg, u_reg, rm_reg, sr_reg;
    logic [63:0] ne_reg, inve_reg, gv_reg, km_reg, hv_reg, om_reg, vel_reg, acl_reg;
    logic        kneg_reg;
    logic [30:0] pos_reg;

    logic               out_valid_reg;
    logic [31:0]        sample_time_reg;
    logic [30:0]        position_reg;
    logic [47:0]        velocity_reg;
    logic [47:0]        acceleration_reg;
    logic               last_reg;
    logic               status_reg;

    logic [31:0] dur;
    logic        err;
    logic [32:0] lastk;
    logic [32:0] k_comb;
    logic        cneg;
    logic [32:0] xm;
    logic        hneg;
    logic [30:0] hm;
    logic [63:0] onem;
    logic [3:0]  j2;
    logic [7:0]  sin_d;
    logic [7:0]  cos_d;
    logic [7:0]  div_k;
    logic [39:0] qd;
    logic [39:0] qrem;
    logic [63:0] q_fix;
    logic [32:0] st_sum;
    logic        is_last;

    unit_t       sel;
    logic [63:0] mul_a, mul_b, div_n, div_d, sq_v;
    logic [5:0]  mul_sh;
    logic        mul_done, div_done, sq_done, done;
    logic [63:0] mres, dq, dr, sres;
    logic [63:0] p_half, kp, kn, ee_sum, dpos_sum;

    assign dur = cfg.end_time - cfg.start_time;
    assign err = (cfg.end_time <= cfg.start_time) || (cfg.sample_interval == 20'd0)
                 || (cfg.axis_ratio == 16'd0);
    assign lastk = {1'b0, whole_reg} + 33'(remnz_reg);
    assign k_comb = ({1'b0, idx_reg} > lastk) ? lastk : {1'b0, idx_reg};
    assign cneg = x_reg > 33'h080000000;
    assign xm = cneg ? (33'h100000000 - x_reg) : x_reg;
    assign hneg = cfg.end_position < cfg.start_position;
    assign hm = hneg ? (cfg.start_position - cfg.end_position)
                     : (cfg.end_position - cfg.start_position);
    assign onem = cneg ? (ONE_Q30 + rm_reg) : (ONE_Q30 - rm_reg);
    assign j2 = {j_reg, 1'b0};
    assign sin_d = 8'(j2) * (8'(j2) + 8'd1);
    assign cos_d = (8'(j2) - 8'd1) * 8'(j2);
    assign div_k = (cmd.op == OP_SIN_DIV) ? sin_d : cos_d;
    assign qd = 40'(mres[31:0]) * 40'(div_k);
    assign qrem = tmp_reg[39:0] - qd;
    assign q_fix = (qrem >= 40'(div_k)) ? (mres + 64'd1) : mres;
    assign st_sum = {1'b0, cfg.start_time} + {1'b0, tau_reg};
    assign is_last = k_reg == lastk;

    assign p_half = mres >> 1;
    assign kp = ONE_Q30 + 64'd3 * mres;
    assign kn = 64'd3 * u_reg;
    assign ee_sum = mres + s2_reg;
    assign dpos_sum = 64'(cfg.start_position) + mres;

    always_comb
    begin
        sel = U_MUL;
        mul_a = '0;
        mul_b = '0;
        mul_sh = 6'd0;
        div_n = '0;
        div_d = 64'd1;
        sq_v = '0;
        case (cmd.op)
            OP_DUR:
            begin
                sel = U_DIV;
                div_n = 64'(dur);
                div_d = 64'(cfg.sample_interval);
            end
            OP_KSI:
            begin
                mul_a = 64'(k_comb);
                mul_b = 64'(cfg.sample_interval);
            end
            OP_PHASE:
            begin
                sel = U_DIV;
                div_n = {tau_reg, 32'b0};
                div_d = 64'(dur);
            end
            OP_ANG:
            begin
                mul_a = 64'(xm);
                mul_b = PI_Q30;
                mul_sh = 6'd32;
            end
            OP_A2:
            begin
                mul_a = ang_reg;
                mul_b = ang_reg;
                mul_sh = 6'd30;
            end
            OP_SIN_MUL, OP_COS_MUL, OP_COS:
            begin
                mul_a = a2_reg;
                mul_b = acc_reg;
                mul_sh = 6'd30;
            end
            OP_SIN_DIV, OP_COS_DIV:
            begin
                mul_a = tmp_reg;
                mul_b = recip_q40(div_k);
                mul_sh = 6'd40;
            end
            OP_SIN:
            begin
                mul_a = ang_reg;
                mul_b = acc_reg;
                mul_sh = 6'd30;
            end
            OP_C2:
            begin
                mul_a = cs_reg;
                mul_b = cs_reg;
                mul_sh = 6'd30;
            end
            OP_S2:
            begin
                mul_a = sn_reg;
                mul_b = sn_reg;
                mul_sh = 6'd30;
            end
            OP_RR:
            begin
                mul_a = 64'(cfg.axis_ratio);
                mul_b = 64'(cfg.axis_ratio);
            end
            OP_EE:
            begin
                mul_a = rr_reg;
                mul_b = c2_reg;
                mul_sh = 6'd16;
            end
            OP_U:
            begin
                sel = U_DIV;
                div_n = s2_reg << 30;
                div_d = ee_reg;
            end
            OP_RM:
            begin
                sel = U_SQRT;
                sq_v = (ONE_Q30 - u_reg) << 30;
            end
            OP_SR:
            begin
                sel = U_SQRT;
                sq_v = u_reg << 30;
            end
            OP_NE:
            begin
                sel = U_DIV;
                div_n = 64'(cfg.axis_ratio) << 46;
                div_d = ee_reg;
            end
            OP_INVE:
            begin
                sel = U_DIV;
                div_n = 64'd1 << 60;
                div_d = ee_reg;
            end
            OP_GV:
            begin
                mul_a = sr_reg;
                mul_b = ne_reg;
                mul_sh = 6'd24;
            end
            OP_KP:
            begin
                mul_a = u_reg;
                mul_b = rr_reg;
                mul_sh = 6'd16;
            end
            OP_HV1:
            begin
                mul_a = rm_reg;
                mul_b = inve_reg;
                mul_sh = 6'd30;
            end
            OP_HV:
            begin
                mul_a = tmp_reg;
                mul_b = km_reg;
                mul_sh = 6'd30;
            end
            OP_DPOS:
            begin
                mul_a = 64'(hm);
                mul_b = onem;
                mul_sh = 6'd31;
            end
            OP_OM:
            begin
                sel = U_DIV;
                div_n = OMEGA_NUM;
                div_d = 64'(dur);
            end
            OP_VEL1:
            begin
                mul_a = 64'(hm);
                mul_b = gv_reg;
                mul_sh = 6'd16;
            end
            OP_VEL, OP_ACL:
            begin
                mul_a = tmp_reg;
                mul_b = om_reg;
                mul_sh = 6'd55;
            end
            OP_ACL1:
            begin
                mul_a = 64'(hm);
                mul_b = hv_reg;
                mul_sh = 6'd16;
            end
            OP_ACL2:
            begin
                mul_a = tmp_reg;
                mul_b = om_reg;
                mul_sh = 6'd40;
            end
            default:
            begin
                sel = U_MUL;
            end
        endcase
    end

    etg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.issue && (sel == U_MUL)),
        .a     (mul_a),
        .b     (mul_b),
        .sh    (mul_sh),
        .done  (mul_done),
        .res   (mres)
    );

    etg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.issue && (sel == U_DIV)),
        .n     (div_n),
        .d     (div_d),
        .done  (div_done),
        .q     (dq),
        .r     (dr)
    );

    etg_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.issue && (sel == U_SQRT)),
        .v     (sq_v),
        .done  (sq_done),
        .s     (sres)
    );

    assign done = mul_done | div_done | sq_done;

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            case (cmd.op)
                OP_DUR:
                begin
                    whole_reg <= dq[31:0];
                    remnz_reg <= dr != 64'd0;
                end
                OP_KSI:
                begin
                    k_reg <= k_comb;
                    tau_reg <= (k_comb <= {1'b0, whole_reg}) ? mres[31:0] : dur;
                end
                OP_PHASE:   x_reg <= dq[32:0];
                OP_ANG:     ang_reg <= mres;
                OP_A2:
                begin
                    a2_reg <= mres;
                    acc_reg <= ONE_Q30;
                    j_reg <= 3'd7;
                end
                OP_SIN_MUL, OP_COS_MUL, OP_HV1, OP_VEL1, OP_ACL1, OP_ACL2:
                begin
                    tmp_reg <= mres;
                end
                OP_SIN_DIV, OP_COS_DIV:
                begin
                    acc_reg <= ONE_Q30 - q_fix;
                    j_reg <= j_reg - 3'd1;
                end
                OP_SIN:
                begin
                    sn_reg <= (mres > ONE_Q30) ? ONE_Q30 : mres;
                    acc_reg <= ONE_Q30;
                    j_reg <= 3'd7;
                end
                OP_COS:     cs_reg <= (p_half >= ONE_Q30) ? 64'd0 : (ONE_Q30 - p_half);
                OP_C2:      c2_reg <= mres;
                OP_S2:      s2_reg <= mres;
                OP_RR:      rr_reg <= mres;
                OP_EE:      ee_reg <= (ee_sum == 64'd0) ? 64'd1 : ee_sum;
                OP_U:       u_reg <= dq;
                OP_RM:      rm_reg <= sres;
                OP_SR:      sr_reg <= sres;
                OP_NE:      ne_reg <= dq;
                OP_INVE:    inve_reg <= dq;
                OP_GV:      gv_reg <= mres;
                OP_KP:
                begin
                    kneg_reg <= kp < kn;
                    km_reg <= (kp < kn) ? (kn - kp) : (kp - kn);
                end
                OP_HV:      hv_reg <= mres;
                OP_DPOS:
                begin
                    if (hneg)
                    begin
                        pos_reg <= (mres > 64'(cfg.start_position)) ? 31'd0
                                   : (cfg.start_position - mres[30:0]);
                    end
                    else
                    begin
                        pos_reg <= (dpos_sum > 64'h7FFFFFFF) ? 31'h7FFFFFFF
                                   : dpos_sum[30:0];
                    end
                end
                OP_OM:      om_reg <= dq;
                OP_VEL:     vel_reg <= mres;
                OP_ACL:     acl_reg <= mres;
                default:
                begin
                    tmp_reg <= tmp_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept && restart)
            begin
                active_reg <= 1'b1;
                idx_reg <= 32'd0;
            end
            else if (cmd.load_err || (cmd.load_ok && is_last))
            begin
                active_reg <= 1'b0;
                idx_reg <= 32'd0;
            end
            else if (cmd.load_ok)
            begin
                idx_reg <= k_reg[31:0] + 32'd1;
            end
            if (cmd.load_ok || cmd.load_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_err)
        begin
            sample_time_reg <= 32'd0;
            position_reg <= 31'd0;
            velocity_reg <= 48'd0;
            acceleration_reg <= 48'd0;
            last_reg <= 1'b1;
            status_reg <= 1'b1;
        end
        else if (cmd.load_ok)
        begin
            sample_time_reg <= st_sum[32] ? 32'hFFFFFFFF : st_sum[31:0];
            position_reg <= pos_reg;
            velocity_reg <= sat48(vel_reg, hneg);
            acceleration_reg <= sat48(acl_reg, hneg ^ cneg ^ kneg_reg);
            last_reg <= is_last;
            status_reg <= 1'b0;
        end
    end

    assign stat.go = restart || active_reg;
    assign stat.err = err;
    assign stat.done = done;
    assign stat.j_last = (cmd.op == OP_SIN_DIV) ? (j_reg == 3'd1) : (j_reg == 3'd2);
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign sample_time = sample_time_reg;
    assign position = position_reg;
    assign velocity = velocity_reg;
    assign acceleration = acceleration_reg;
    assign last = last_reg;
    assign status = status_reg;

endmodule

>>> rtl/etg_ctrl.sv
module etg_ctrl
    import etg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_DUR;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        in_stall = 1'b1;
        cmd.accept = 1'b0;
        cmd.issue = 1'b0;
        cmd.load_ok = 1'b0;
        cmd.load_err = 1'b0;
        cmd.op = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.accept = in_valid;
                if (in_valid && stat.go)
                begin
                    if (stat.err)
                    begin
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        op_next = OP_DUR;
                    end
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (stat.done)
                begin
                    state_next = ST_ISSUE;
                    case (op_reg)
                        OP_SIN_DIV: op_next = stat.j_last ? OP_SIN : OP_SIN_MUL;
                        OP_COS_DIV: op_next = stat.j_last ? OP_COS : OP_COS_MUL;
                        OP_ACL:     state_next = ST_OUT;
                        default:    op_next = op_t'(5'(op_reg) + 5'd1);
                    endcase
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_ok = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.load_err = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> tb/sv/tb_elliptic_trajectory_generator.sv
module tb_elliptic_trajectory_generator;
    import etg_pkg::*;

    typedef struct {
        logic [31:0] t;
        logic [30:0] p;
        logic [47:0] v;
        logic [47:0] a;
        logic        l;
        logic        s;
    } sample_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               restart;
    logic               out_valid;
    logic               out_stall;
    logic [31:0]        sample_time;
    logic [30:0]        position;
    logic signed [47:0] velocity;
    logic signed [47:0] acceleration;
    logic               last;
    logic               status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    sample_t     pending_samples[$];
    int          mismatches;
    int          beats_sent;
    int          hold_left;
    logic [63:0] t_begin, t_end, p_begin, p_end, t_step, ratio;
    logic [31:0] move_index;
    bit          move_active;

    elliptic_trajectory_generator uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .restart(restart),
        .out_valid(out_valid), .out_stall(out_stall),
        .sample_time(sample_time), .position(position), .velocity(velocity),
        .acceleration(acceleration), .last(last), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #400000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [63:0] wide_mul(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] pr;
        pr = {64'd0, a} * {64'd0, b};
        if ((pr >> (64 + sh)) != 0)
            return 64'hFFFF_FFFF_FFFF_FFFF;
        pr = pr >> sh;
        return pr[63:0];
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [47:0] clamp_signed(logic [63:0] mag, bit neg);
        logic [63:0] m;
        m = mag;
        if (neg)
        begin
            if (m > MAG_NEG_MAX)
                m = MAG_NEG_MAX;
            m = ~m + 1;
            return m[47:0];
        end
        if (m > MAG_POS_MAX)
            m = MAG_POS_MAX;
        return m[47:0];
    endfunction

    function automatic void ellipse_point(input logic [63:0] x, input logic [63:0] dur,
                                          inout sample_t smp);
        bit          cneg, kneg, hneg;
        logic [63:0] xm, ang, a2, acc, sn, cs, pp, dv, c2, s2, rr, ee, u, rm, sr;
        logic [63:0] ne, inve, gv, kp, kn, km, hv, hm, onem, dpos, pos, om, vel, acl;
        int          j;
        cneg = x > (64'd1 << 31);
        xm = cneg ? (64'd1 << 32) - x : x;
        ang = (xm * PI_Q30) >> 32;
        a2 = (ang * ang) >> 30;
        acc = ONE_Q30;
        for (j = 7; j >= 1; j--)
        begin
            dv = 64'((2 * j) * (2 * j + 1));
            acc = ONE_Q30 - ((a2 * acc) >> 30) / dv;
        end
        sn = (ang * acc) >> 30;
        if (sn > ONE_Q30)
            sn = ONE_Q30;
        acc = ONE_Q30;
        for (j = 7; j >= 2; j--)
        begin
            dv = 64'((2 * j - 1) * (2 * j));
            acc = ONE_Q30 - ((a2 * acc) >> 30) / dv;
        end
        pp = ((a2 * acc) >> 30) / 64'd2;
        cs = (pp >= ONE_Q30) ? 64'd0 : ONE_Q30 - pp;
        c2 = (cs * cs) >> 30;
        s2 = (sn * sn) >> 30;
        rr = ratio * ratio;
        ee = ((rr * c2) >> 16) + s2;
        if (ee == 0)
            ee = 1;
        u = (s2 << 30) / ee;
        rm = int_root((ONE_Q30 - u) << 30);
        sr = int_root(u << 30);
        ne = (ratio << 46) / ee;
        inve = (64'd1 << 60) / ee;
        gv = wide_mul(sr, ne, 24);
        kp = ONE_Q30 + 64'd3 * ((u * rr) >> 16);
        kn = 64'd3 * u;
        kneg = kp < kn;
        km = kneg ? kn - kp : kp - kn;
        hv = wide_mul(wide_mul(rm, inve, 30), km, 30);
        hneg = p_end < p_begin;
        hm = hneg ? p_begin - p_end : p_end - p_begin;
        onem = cneg ? ONE_Q30 + rm : ONE_Q30 - rm;
        dpos = wide_mul(hm, onem, 31);
        if (hneg)
            pos = (dpos > p_begin) ? 64'd0 : p_begin - dpos;
        else
            pos = (p_begin + dpos > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : p_begin + dpos;
        om = OMEGA_NUM / dur;
        vel = wide_mul(wide_mul(hm, gv, 16), om, 55);
        acl = wide_mul(wide_mul(wide_mul(hm, hv, 16), om, 40), om, 55);
        smp.p = pos[30:0];
        smp.v = clamp_signed(vel, hneg);
        smp.a = clamp_signed(acl, hneg ^ cneg ^ kneg);
    endfunction

    task automatic predict_beat(bit rs);
        sample_t     smp;
        logic [63:0] dur, whole, last_k, k, tau, tsum;
        if (rs)
        begin
            move_index = 0;
            move_active = 1;
        end
        else if (!move_active)
            return;
        if (t_end <= t_begin || t_step == 0 || ratio == 0)
        begin
            smp = '{t: 0, p: 0, v: 0, a: 0, l: 1, s: 1};
            pending_samples.push_back(smp);
            move_active = 0;
            move_index = 0;
            return;
        end
        dur = t_end - t_begin;
        whole = dur / t_step;
        last_k = whole + (((dur % t_step) != 0) ? 64'd1 : 64'd0);
        k = 64'(move_index);
        if (k > last_k)
            k = last_k;
        tau = (k <= whole) ? k * t_step : dur;
        ellipse_point((tau << 32) / dur, dur, smp);
        tsum = t_begin + tau;
        smp.t = (tsum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tsum[31:0];
        smp.l = (k == last_k);
        smp.s = 0;
        if (k == last_k)
        begin
            move_active = 0;
            move_index = 0;
        end
        else
            move_index = 32'(k + 64'd1);
        pending_samples.push_back(smp);
    endtask

    task automatic send_beat(bit rs, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        restart <= rs;
        do
            @(posedge clk);
        while (in_stall);
        predict_beat(rs);
        beats_sent++;
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 8);
        return $urandom_range(50, 2000);
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic load_config(logic [31:0] st, logic [31:0] et, logic [30:0] sp,
                               logic [30:0] ep, logic [19:0] dt, logic [15:0] ar);
        logic [31:0] vals[6];
        logic [2:0]  idx[6];
        int          i;
        vals = '{st, et, {1'b0, sp}, {1'b0, ep}, {12'd0, dt}, {16'd0, ar}};
        idx = '{CFG_START_TIME, CFG_END_TIME, CFG_START_POSITION, CFG_END_POSITION,
                CFG_SAMPLE_INTERVAL, CFG_AXIS_RATIO};
        for (i = 0; i < 6; i++)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        t_begin = st;
        t_end = et;
        p_begin = sp;
        p_end = ep;
        t_step = dt;
        ratio = ar;
    endtask

    initial
    begin
        int cnt;
        int r;
        cnt = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (cnt == 0)
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                begin
                    out_stall <= 1'b0;
                    cnt = $urandom_range(1, 20);
                end
                else if (r < 9)
                begin
                    out_stall <= 1'b1;
                    cnt = $urandom_range(1, 4);
                end
                else
                begin
                    out_stall <= 1'b1;
                    cnt = $urandom_range(20, 300);
                end
            end
            else
                cnt--;
        end
    end

    initial
    begin
        sample_t smp;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_samples.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected beat: time %h pos %h", sample_time, position);
                end
                else
                begin
                    smp = pending_samples.pop_front();
                    if (sample_time !== smp.t || position !== smp.p || velocity !== smp.v
                        || acceleration !== smp.a || last !== smp.l || status !== smp.s)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("Mismatch: expected t=%h p=%h v=%h a=%h l=%b s=%b",
                                     smp.t, smp.p, smp.v, smp.a, smp.l, smp.s);
                            $display("          got      t=%h p=%h v=%h a=%h l=%b s=%b",
                                     sample_time, position, velocity, acceleration,
                                     last, status);
                        end
                    end
                end
            end
        end
    end

    task automatic test_reset_values();
        send_beat(1'b1, 0);
        send_beat(1'b0, 0);
        send_beat(1'b0, 3);
        wait_idle();
    endtask

    task automatic test_param_errors();
        load_config(32'd100, 32'd100, 31'd5, 31'd900, 20'd10, 16'd256);
        send_beat(1'b1, 0);
        send_beat(1'b0, 0);
        wait_idle();
        load_config(32'd100, 32'd1100, 31'd5, 31'd900, 20'd0, 16'd256);
        send_beat(1'b1, 0);
        wait_idle();
        load_config(32'd100, 32'd1100, 31'd5, 31'd900, 20'd300, 16'd0);
        send_beat(1'b1, 0);
        wait_idle();
    endtask

    task automatic test_rising_move();
        load_config(32'd0, 32'd1000, 31'd0, 31'h7FFF_FFFF, 20'd300, 16'd512);
        send_beat(1'b1, 0);
        repeat (5) send_beat(1'b0, random_gap());
        wait_idle();
    endtask

    task automatic test_falling_move();
        load_config(32'hFFFF_FF00, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'd0, 20'hFFFFF, 16'hFFFF);
        send_beat(1'b1, 0);
        send_beat(1'b1, 0);
        send_beat(1'b0, 0);
        wait_idle();
        load_config(32'd7, 32'd507, 31'h4000_0000, 31'h0123_4567, 20'd100, 16'd1);
        send_beat(1'b1, 0);
        send_beat(1'b0, 1);
        wait_idle();
    endtask

    task automatic test_mid_move_change();
        load_config(32'd0, 32'd5000, 31'd1000, 31'h0100_0000, 20'd500, 16'd300);
        send_beat(1'b1, 0);
        send_beat(1'b0, 0);
        send_beat(1'b0, 0);
        wait_idle();
        load_config(32'd0, 32'd700, 31'd1000, 31'h0100_0000, 20'd500, 16'd300);
        send_beat(1'b0, 0);
        send_beat(1'b1, 0);
        wait_idle();
        load_config(32'd0, 32'd700, 31'd1000, 31'h0100_0000, 20'd500, 16'd0);
        send_beat(1'b0, 0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        int i;
        load_config(32'd1000, 32'd11000, 31'd77, 31'h0300_0000, 20'd1000, 16'd200);
        hold_left = 8000;
        send_beat(1'b1, 0);
        for (i = 0; i < 10; i++)
            send_beat(1'b0, 0);
        wait_idle();
    endtask

    task automatic test_random_moves();
        logic [31:0] st, et, span;
        logic [19:0] dt;
        logic [15:0] ar;
        int          ticks, i, r;
        while (beats_sent < 1000)
        begin
            wait_idle();
            st = $urandom();
            if ($urandom_range(0, 3) == 0)
                st = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            span = $urandom_range(1, 20000);
            et = st + span;
            if ($urandom_range(0, 15) == 0)
                et = $urandom();
            dt = 20'(span / $urandom_range(1, 7) + $urandom_range(0, 3));
            if ($urandom_range(0, 12) == 0)
                dt = 20'($urandom());
            if (dt == 0 && $urandom_range(0, 3) != 0)
                dt = 20'd1;
            ar = 16'($urandom());
            r = $urandom_range(0, 9);
            if (r < 3)
                ar = 16'($urandom_range(1, 512));
            else if (r == 3)
                ar = 16'($urandom_range(0, 2));
            load_config(st, et, 31'($urandom()), 31'($urandom()), dt, ar);
            if ($urandom_range(0, 7) == 0)
                send_beat(1'b0, random_gap());
            send_beat(1'b1, random_gap());
            ticks = $urandom_range(1, 10);
            for (i = 0; i < ticks; i++)
                send_beat(($urandom_range(0, 19) == 0), random_gap());
        end
        wait_idle();
    endtask

    initial
    begin
        mismatches = 0;
        beats_sent = 0;
        hold_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        restart = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_START_TIME;
        cfg_data = 32'd0;
        t_begin = 0;
        t_end = 1000000;
        p_begin = 0;
        p_end = 0;
        t_step = 1000;
        ratio = 256;
        move_index = 0;
        move_active = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);
        test_reset_values();
        test_param_errors();
        test_rising_move();
        test_falling_move();
        test_mid_move_change();
        test_backpressure();
        test_random_moves();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending_samples.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
